@@ rtl/etb_pkg.sv @@
package etb_pkg;

   // Width of a node number on the ports and in the ancestor store.
   localparam int NODE_W = 11;

   // Default node count of the tree.
   localparam int NODES_DEFAULT = 1024;

endpackage

@@ rtl/etb_anc_ram.sv @@
module etb_anc_ram #(
   parameter int NODES = etb_pkg::NODES_DEFAULT,
   localparam int AW = $clog2(NODES)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [etb_pkg::NODE_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [etb_pkg::NODE_W-1:0]  rd_data
);

   logic [etb_pkg::NODE_W-1:0] store_mem [NODES];
   logic [etb_pkg::NODE_W-1:0] rd_q_ff;
   logic [etb_pkg::NODE_W-1:0] fwd_data_ff;
   logic                       fwd_ff;

   // Read old data; bypass the word written in the same cycle at the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= store_mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

@@ rtl/elimination_tree_builder_unit.sv @@
// Elimination tree builder, ancestor walk with path compression.
// Steps: an item without a walk is done on acceptance; a walking item reads one ancestor
//   entry per step, then its link waits for room in the output register (rsp_ready).
// One item at a time: req_ready is low while a walk runs; each walk step waits on the store read.
// Reset: synchronous, active high; then a clearing pass zeroes all NODES store entries
//   while req_ready stays low.
module elimination_tree_builder_unit #(
   parameter int NODES = etb_pkg::NODES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [etb_pkg::NODE_W-1:0]  req_column,
   input  logic [etb_pkg::NODE_W-1:0]  req_neighbor,
   input  logic                        req_first_of_column,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [etb_pkg::NODE_W-1:0]  rsp_child_node,
   output logic [etb_pkg::NODE_W-1:0]  rsp_parent_node
);

   localparam int AW = $clog2(NODES);
   localparam int NW = etb_pkg::NODE_W;
   localparam logic [31:0] NodesVal = 32'(NODES);
   localparam logic [AW-1:0] LastAddr = AW'(NODES - 1);

   localparam logic [1:0] ST_CLR  = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [NW-1:0] col_ff, col_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_child_ff, rsp_child_in;
   logic [NW-1:0] rsp_parent_ff, rsp_parent_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [NW-1:0] wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [NW-1:0] rd_data;

   logic          req_fire;
   logic          col_ok;
   logic          nbr_ok;
   logic          can_emit;
   logic          nxt_is_root;

   etb_anc_ram #(.NODES(NODES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // A column of zero or beyond the tree is dropped whole.
   assign col_ok = (req_column != '0) && ({{(32-NW){1'b0}}, req_column} <= NodesVal);
   // Only a neighbor strictly below the column starts a walk.
   assign nbr_ok = col_ok && (req_neighbor != '0) && (req_neighbor < req_column);

   // The output register can take a new word when empty or draining this cycle.
   assign can_emit = !rsp_valid_ff || rsp_ready;

   // An empty entry (or one outside the tree) marks the root of the chain.
   assign nxt_is_root = (rd_data == '0) || ({{(32-NW){1'b0}}, rd_data} > NodesVal);

   // Each visited entry is rewritten to the column, so a chain can never revisit a node
   // without meeting the column first; the walk is bounded by NODES steps on its own.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      col_in        = col_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_child_in  = rsp_child_ff;
      rsp_parent_in = rsp_parent_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(cur_ff - NW'(1));
      wr_data       = col_ff;
      rd_en         = 1'b0;
      rd_addr       = AW'(req_neighbor - NW'(1));

      case (state_ff)
         ST_CLR: begin
            // Sweep the store to zero, one entry a cycle.
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (col_ok && req_first_of_column) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(req_column - NW'(1));
                  wr_data = '0;
               end
               if (nbr_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(req_neighbor - NW'(1));
                  col_in   = req_column;
                  cur_in   = req_neighbor;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (rd_data == col_ff) begin
               // Already linked to this column: drop.
               state_in = ST_IDLE;
            end else if (nxt_is_root) begin
               // Link the root to the column; hold while the output is full.
               if (can_emit) begin
                  wr_en         = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_child_in  = cur_ff;
                  rsp_parent_in = col_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               // Compress this entry and advance to its ancestor.
               wr_en   = 1'b1;
               rd_en   = 1'b1;
               rd_addr = AW'(rd_data - NW'(1));
               cur_in  = rd_data;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff        <= col_in;
      cur_ff        <= cur_in;
      rsp_child_ff  <= rsp_child_in;
      rsp_parent_ff <= rsp_parent_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_child_node  = rsp_child_ff;
   assign rsp_parent_node = rsp_parent_ff;

   // The walk never stands on the column's own node.
   a_walk_not_self: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (cur_ff != col_ff))
      else $error("walk reached the column node");

   // A result always names real nodes.
   a_rsp_nodes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_child_ff != '0) && (rsp_parent_ff != '0)
                       && ({{(32-NW){1'b0}}, rsp_parent_ff} <= NodesVal))
      else $error("result names an invalid node");

   // The clearing pass ends in idle after its last entry.
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) && (clr_cnt_ff == LastAddr) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not finish");

   // An accepted word with a neighbor below its column starts a walk.
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && nbr_ok |=> (state_ff == ST_WALK))
      else $error("walk did not start");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES        = etb_pkg::NODES_DEFAULT;
   localparam int WORD_TARGET  = 1550;
   localparam int CALM_TAIL    = 150;
   localparam int CYCLE_LIMIT  = 5_000_000;
   // Longest walk touches every store entry once.
   localparam int DRAIN_CYCLES = 2 * NODES + 16;
   localparam int REPORT_MAX   = 10;

   typedef bit [etb_pkg::NODE_W-1:0] node_type;

   // How a stimulus row gets its expectation: from the tree model, typed in, or none at all.
   typedef enum {ROW_PREDICT, ROW_NONE, ROW_LINK} row_kind_type;

   typedef struct {
      node_type     column;
      node_type     neighbor;
      bit           first;
      row_kind_type kind;
      node_type     child;
      node_type     parent;
   } stim_row_type;

   typedef struct {
      node_type child;
      node_type parent;
   } tree_link_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [etb_pkg::NODE_W-1:0] req_column = '0;
   logic [etb_pkg::NODE_W-1:0] req_neighbor = '0;
   logic                       req_first_of_column = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [etb_pkg::NODE_W-1:0] rsp_child_node;
   logic [etb_pkg::NODE_W-1:0] rsp_parent_node;

   // Tree model state: ancestor entry of each node, 0 = none.
   node_type      ancestor_of [1:NODES];
   tree_link_type pending_links [$];

   int  cycle_count    = 0;
   int  words_counted  = 0;
   int  words_total    = 0;
   int  links_expected = 0;
   int  links_checked  = 0;
   int  windows_built  = 0;
   int  mismatches     = 0;
   bit  calm           = 1'b0;
   bit  gaps_on        = 1'b1;

   // Directed rows, store all zero after reset. Rows with a typed answer
   // are the ones that can be read straight off the algorithm.
   stim_row_type directed_rows [22] = '{
      // column zero: ignored, nothing cleared
      '{11'd0,    11'd0,    1'b1, ROW_NONE,    11'd0,    11'd0},
      // columns above the node count, the first with every bit set: ignored
      '{11'd2047, 11'd5,    1'b1, ROW_NONE,    11'd0,    11'd0},
      '{11'd1025, 11'd1,    1'b0, ROW_NONE,    11'd0,    11'd0},
      // neighbor zero: clear only
      '{11'd1,    11'd0,    1'b1, ROW_NONE,    11'd0,    11'd0},
      // first real link, node 1 is a root
      '{11'd2,    11'd1,    1'b1, ROW_LINK,    11'd1,    11'd2},
      // entry already equals the column: walk stops at once
      '{11'd2,    11'd1,    1'b0, ROW_NONE,    11'd0,    11'd0},
      // neighbor equal to column, then neighbor above it with all bits set
      '{11'd2,    11'd2,    1'b0, ROW_NONE,    11'd0,    11'd0},
      '{11'd2,    11'd2047, 1'b0, ROW_NONE,    11'd0,    11'd0},
      '{11'd3,    11'd1,    1'b1, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd3,    11'd2,    1'b0, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd5,    11'd4,    1'b1, ROW_LINK,    11'd4,    11'd5},
      '{11'd5,    11'd1,    1'b0, ROW_PREDICT, 11'd0,    11'd0},
      // top of the node range
      '{11'd1024, 11'd1023, 1'b1, ROW_LINK,    11'd1023, 11'd1024},
      '{11'd1024, 11'd1,    1'b0, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd1024, 11'd1024, 1'b1, ROW_NONE,    11'd0,    11'd0},
      // columns out of order from here on
      '{11'd1000, 11'd999,  1'b0, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd1000, 11'd1,    1'b0, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd1023, 11'd1024, 1'b1, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd1000, 11'd1,    1'b1, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd1024, 11'd1022, 1'b0, ROW_PREDICT, 11'd0,    11'd0},
      '{11'd1024, 11'd999,  1'b0, ROW_PREDICT, 11'd0,    11'd0},
      // compressed step, then an entry equal to the column ends the walk
      '{11'd1024, 11'd1,    1'b0, ROW_PREDICT, 11'd0,    11'd0}
   };

   elimination_tree_builder_unit #(.NODES(NODES)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_column          (req_column),
      .req_neighbor        (req_neighbor),
      .req_first_of_column (req_first_of_column),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_child_node      (rsp_child_node),
      .rsp_parent_node     (rsp_parent_node)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Hard stop: a hung walk or a lost link never lets the run end cleanly.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d links still pending",
               cycle_count, pending_links.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Walk the ancestor chain of one word, compressing it onto the column.
   // Returns 1 and the root when a new link is formed.
   function automatic bit walk_to_root(input node_type col, input node_type nbr,
                                       input bit first, output node_type root);
      node_type cur;
      node_type nxt;
      int       hops;
      root = '0;
      if (col == 0 || col > NODES) return 1'b0;
      if (first) ancestor_of[col] = '0;
      if (nbr == 0 || nbr >= col) return 1'b0;
      cur = nbr;
      for (hops = 0; hops <= NODES; hops++) begin
         nxt = ancestor_of[cur];
         // already compressed onto this column: nothing new
         if (nxt == col) return 1'b0;
         if (nxt == 0 || nxt > NODES) break;
         ancestor_of[cur] = col;
         cur = nxt;
      end
      // runaway chain: give up without a link
      if (hops > NODES) return 1'b0;
      ancestor_of[cur] = col;
      root = cur;
      return 1'b1;
   endfunction

   // Offer one word, hold it until accepted, then book its expected link.
   task automatic send_word(input node_type col, input node_type nbr, input bit first,
                            input row_kind_type kind, input node_type t_child,
                            input node_type t_parent);
      node_type root;
      bit       linked;
      req_valid           <= 1'b1;
      req_column          <= col;
      req_neighbor        <= nbr;
      req_first_of_column <= first;
      // Values read right after the edge are the ones the edge sampled.
      do @(posedge clock); while (!req_ready);
      linked = walk_to_root(col, nbr, first, root);
      case (kind)
         ROW_PREDICT: begin
            if (linked) pending_links.push_back('{root, col});
         end
         ROW_LINK: begin
            pending_links.push_back('{t_child, t_parent});
         end
         default: ;
      endcase
      if (kind == ROW_LINK || (kind == ROW_PREDICT && linked)) links_expected++;
      words_total++;
      if (col != 0 && col <= NODES) words_counted++;
      calm = (words_counted >= WORD_TARGET - CALM_TAIL);
      // Drop valid for a burst now and then; otherwise the next word
      // follows back to back.
      if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // One well-formed stretch of columns: a small permuted matrix placed
   // somewhere in the node range, with the odd broken column mixed in.
   task automatic build_window();
      int unsigned span;
      int unsigned base;
      int unsigned c;
      int unsigned j;
      int unsigned per_col;
      bit          keep_clear;
      node_type    nbr;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(2, 40);
      base = $urandom_range(1, NODES + 1 - span);
      gaps_on = ($urandom_range(0, 3) != 0);
      windows_built++;
      for (c = base; c < base + span; c++) begin
         per_col = $urandom_range(1, 4);
         // Skip the column clear once in a while: stale entry survives.
         keep_clear = ($urandom_range(0, 24) != 0);
         for (j = 0; j < per_col; j++) begin
            // Stop the window once the word budget is spent.
            if (words_counted >= WORD_TARGET) return;
            if (c == base || $urandom_range(0, 9) == 0)
               nbr = ($urandom_range(0, 1) != 0) ? node_type'(c) : node_type'(0);
            else if ($urandom_range(0, 29) == 0)
               nbr = node_type'($urandom_range(1, c - 1));
            else
               nbr = node_type'($urandom_range(base, c - 1));
            send_word(node_type'(c), nbr, keep_clear && (j == 0), ROW_PREDICT, '0, '0);
         end
      end
   endtask

   // Unstructured words: bad columns, out-of-order columns, any neighbor.
   task automatic send_noise();
      int unsigned pick;
      node_type    col;
      pick = $urandom_range(0, 3);
      case (pick)
         0:       col = '0;
         1:       col = node_type'($urandom_range(NODES + 1, 2047));
         default: col = node_type'($urandom_range(1, NODES));
      endcase
      send_word(col, node_type'($urandom_range(0, 2047)), bit'($urandom_range(0, 1)),
                ROW_PREDICT, '0, '0);
   endtask

   // Result side: stall in random bursts, long stretches of open ready,
   // and no stalls at all once the tail of the run starts.
   initial begin : rsp_throttle
      int unsigned hold;
      bit          level;
      forever begin
         if (calm) begin
            @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            level = ($urandom_range(0, 2) != 0);
            hold  = level ? $urandom_range(1, 60) : $urandom_range(1, 19);
            repeat (hold) begin
               @(posedge clock);
               rsp_ready <= level;
            end
         end
      end
   end

   // Compare every accepted link with the oldest one still owed.
   always @(posedge clock) begin : link_check
      tree_link_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_links.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: link %0d -> %0d arrived with nothing owed",
                        $realtime, rsp_child_node, rsp_parent_node);
         end else begin
            want = pending_links.pop_front();
            links_checked++;
            if (rsp_child_node !== want.child || rsp_parent_node !== want.parent) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: link mismatch child exp %0d got %0d, parent exp %0d got %0d",
                           $realtime, want.child, rsp_child_node,
                           want.parent, rsp_parent_node);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned r;
      int unsigned burst;
      foreach (ancestor_of[n]) ancestor_of[n] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed rows first; the store clearing pass holds ready low a while.
      for (r = 0; r < $size(directed_rows); r++) begin
         send_word(directed_rows[r].column, directed_rows[r].neighbor,
                   directed_rows[r].first, directed_rows[r].kind,
                   directed_rows[r].child, directed_rows[r].parent);
      end

      // Random part: mostly well-formed windows, some noise in between.
      while (words_counted < WORD_TARGET) begin
         if ($urandom_range(0, 6) == 0) begin
            gaps_on = ($urandom_range(0, 1) != 0);
            burst = $urandom_range(1, 5);
            repeat (burst) send_noise();
         end else begin
            build_window();
         end
      end
      req_valid <= 1'b0;

      // Wait for every owed link, then give a slow walk time to misbehave.
      while (pending_links.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words sent (%0d with a legal column) in %0d column windows",
               words_total, words_counted, windows_built);
      $display("%0d tree links predicted, %0d checked, %0d mismatches, %0d cycles",
               links_expected, links_checked, mismatches, cycle_count);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
